// ===== sv/ted_pkg.sv =====
package ted_pkg;

	// Default values for the top-level parameters.
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int START_ADVANCE_DEF = 0;
	localparam int LENGTH_EXTEND_DEF = 0;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ONSET_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_THR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HANG_IN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HANG_OUT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd6;

	// Bit positions inside mode_flags.
	localparam int MODE_HARD  = 0;
	localparam int MODE_SKIP  = 1;
	localparam int MODE_EAGER = 2;
	localparam int MODE_CONT  = 3;
	localparam int MODE_W     = 4;

	// Field widths.
	localparam int THR_W   = 16;
	localparam int HANG_W  = 16;
	localparam int LEN_W   = 24;
	localparam int TIME_W  = 32;
	localparam int OLEN_W  = 25;

	// Output queue depth in result groups (at most one group per frame end).
	localparam int FIFO_DEPTH = 4;

	// One result word.
	typedef struct packed {
		logic [TIME_W-1:0] start;
		logic [OLEN_W-1:0] length;
		logic              status;
	} res_t;

	// All results caused by one input word: one or two.
	typedef struct packed {
		logic two;
		res_t first;
		res_t second;
	} res_pair_t;

endpackage

// ===== sv/threshold_event_detector_unit.sv =====
// Threshold event detector with hangover.
// Input channel: in_valid/in_ready carry one channel sample per word; frame_end
// marks the last channel of a frame. Only frame-end words can cause results.
// Output channel: out_valid/out_ready carry result words (event_start,
// event_length, event_status, last_result); one input word causes at most two
// results, and last_result flags the final one of them.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while the block is idle.
// Results: a word is registered on acceptance in the input register, and its
// results are then written into the output queue, from which they are offered.
// Throughput: one input word per cycle while in_ready is high. The four-group
// output queue absorbs frames that yield two results; in_ready drops when fewer
// than two groups are free.
// Reset: control and state registers reset, sample and queue data do not;
// the queue is emptied and the detector is idle with frame index zero.
// When the receiver stalls, results wait in the queue and input stops once it
// fills; nothing is dropped.
module threshold_event_detector_unit #(
	parameter int SAMPLE_BITS   = ted_pkg::SAMPLE_BITS_DEF,
	parameter int START_ADVANCE = ted_pkg::START_ADVANCE_DEF,
	parameter int LENGTH_EXTEND = ted_pkg::LENGTH_EXTEND_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic                              frame_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ted_pkg::TIME_W-1:0]        event_start,
	output logic [ted_pkg::OLEN_W-1:0]        event_length,
	output logic                              event_status,
	output logic                              last_result,
	input  logic                              cfg_we,
	input  logic [ted_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ted_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ted_pkg::*;

	logic      push;
	res_pair_t push_pair;

	// Threshold test, hangover counters and event reports.
	ted_core #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.START_ADVANCE (START_ADVANCE),
		.LENGTH_EXTEND (LENGTH_EXTEND)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.frame_end (frame_end),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_pair (push_pair)
	);

	// Result queue and output serializer.
	ted_out_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_pair    (push_pair),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_start  (event_start),
		.event_length (event_length),
		.event_status (event_status),
		.last_result  (last_result)
	);

endmodule

// ===== sv/ted_report.sv =====
module ted_report #(
	parameter int START_ADVANCE = 0,
	parameter int LENGTH_EXTEND = 0
) (
	input  logic                        valid_in,
	input  logic                        completed,
	input  logic [ted_pkg::TIME_W-1:0]  span_start,
	input  logic [ted_pkg::TIME_W-1:0]  span_len,
	input  logic [ted_pkg::LEN_W-1:0]   min_length,
	input  logic [ted_pkg::LEN_W-1:0]   max_length,
	input  logic [ted_pkg::MODE_W-1:0]  mode_flags,
	output logic                        ok,
	output ted_pkg::res_t               res
);
	import ted_pkg::*;

	logic              too_short;
	logic              too_long;
	logic [TIME_W-1:0] max_ext;
	logic [TIME_W-1:0] st_crop;
	logic [LEN_W-1:0]  len_crop;

	// Drop empty, negative and short spans.
	assign max_ext   = {{(TIME_W-LEN_W){1'b0}}, max_length};
	assign too_short = (span_len == '0) || span_len[TIME_W-1] ||
		(span_len < {{(TIME_W-LEN_W){1'b0}}, min_length});
	assign too_long  = span_len > max_ext;

	// Crop overlong spans at the start, moving the start forward.
	always_comb begin
		if (too_long) begin
			st_crop  = span_start + (span_len - max_ext);
			len_crop = max_length;
		end else begin
			st_crop  = span_start;
			len_crop = span_len[LEN_W-1:0];
		end
	end

	assign ok = valid_in && !too_short && !(too_long && mode_flags[MODE_SKIP]) &&
		(completed || mode_flags[MODE_CONT]);

	// Apply the start advance with a floor at zero and the length extension.
	always_comb begin
		if (st_crop >= TIME_W'(START_ADVANCE)) begin
			res.start = st_crop - TIME_W'(START_ADVANCE);
		end else begin
			res.start = '0;
		end
		res.length = OLEN_W'(len_crop) + OLEN_W'(LENGTH_EXTEND);
		res.status = completed;
	end

endmodule

// ===== sv/ted_core.sv =====
module ted_core #(
	parameter int SAMPLE_BITS   = 16,
	parameter int START_ADVANCE = 0,
	parameter int LENGTH_EXTEND = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic                              frame_end,
	input  logic                              cfg_we,
	input  logic [ted_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ted_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              push,
	output ted_pkg::res_pair_t                push_pair
);
	import ted_pkg::*;

	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	// Configuration registers.
	logic signed [THR_W-1:0] onset_thr_q;
	logic signed [THR_W-1:0] offset_thr_q;
	logic [HANG_W-1:0]       hang_in_q;
	logic [HANG_W-1:0]       hang_out_q;
	logic [LEN_W-1:0]        min_len_q;
	logic [LEN_W-1:0]        max_len_q;
	logic [MODE_W-1:0]       mode_q;

	// Input register.
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          frame_end_s1;

	// Detector state.
	logic              active_q;
	logic              acc_q;
	logic [HANG_W-1:0] onset_q;
	logic [HANG_W-1:0] offset_q;
	logic [LEN_W-1:0]  chunk_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] stop_q;
	logic [TIME_W-1:0] frame_q;

	// Next-state values.
	logic              active_d;
	logic              acc_d;
	logic [HANG_W-1:0] onset_d;
	logic [HANG_W-1:0] offset_d;
	logic [LEN_W-1:0]  chunk_d;
	logic [TIME_W-1:0] start_d;
	logic [TIME_W-1:0] stop_d;

	logic signed [CMP_W-1:0] samp_ext;
	logic signed [CMP_W-1:0] thr_ext;
	logic              hit;
	logic              acc_new;
	logic              fe_go;
	logic [LEN_W-1:0]  chunk_dec;
	logic              chunk_fire;
	logic [TIME_W-1:0] start_mid;
	logic [TIME_W-1:0] stop_end;
	logic              a_valid;
	logic              b_valid;
	logic              a_ok;
	logic              b_ok;
	res_t              a_res;
	res_t              b_res;
	res_t              eager_res;
	logic              eager_go;

	// Input register: one word per cycle while in_ready is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1    <= sample;
			frame_end_s1 <= frame_end;
		end
	end

	// Per-channel threshold test and frame accumulation.
	assign samp_ext = CMP_W'(sample_s1);
	assign thr_ext  = active_q ? CMP_W'(offset_thr_q) : CMP_W'(onset_thr_q);
	assign hit      = samp_ext > thr_ext;
	assign acc_new  = mode_q[MODE_HARD] ? (acc_q && hit) : (acc_q || hit);
	assign fe_go    = valid_s1 && frame_end_s1;

	// Accumulator after this word; a mode write reloads it and overrides the word's update.
	always_comb begin
		if (cfg_we && (cfg_index == REG_MODE)) begin
			acc_d = cfg_data[MODE_HARD];
		end else if (valid_s1) begin
			acc_d = frame_end_s1 ? mode_q[MODE_HARD] : acc_new;
		end else begin
			acc_d = acc_q;
		end
	end

	assign chunk_dec  = chunk_q - LEN_W'(1);
	assign chunk_fire = (chunk_dec == '0);

	// Frame-end state update.
	always_comb begin
		active_d  = active_q;
		onset_d   = onset_q;
		offset_d  = offset_q;
		chunk_d   = chunk_q;
		start_d   = start_q;
		stop_d    = stop_q;
		start_mid = start_q;
		stop_end  = stop_q;
		eager_go  = 1'b0;
		a_valid   = 1'b0;
		b_valid   = 1'b0;
		if (!active_q) begin
			if (acc_new) begin
				if (onset_q == hang_in_q) begin
					start_d = frame_q;
				end
				if (onset_q == '0) begin
					active_d = 1'b1;
					onset_d  = hang_in_q;
					offset_d = hang_out_q;
					chunk_d  = max_len_q - LEN_W'(hang_in_q);
					eager_go = mode_q[MODE_EAGER];
				end else begin
					onset_d = onset_q - HANG_W'(1);
				end
			end else begin
				onset_d = hang_in_q;
			end
		end else begin
			// Chunk boundary first, then the end test.
			chunk_d = chunk_dec;
			if (chunk_fire) begin
				a_valid   = 1'b1;
				start_mid = frame_q;
				stop_end  = frame_q;
				chunk_d   = max_len_q;
			end
			if (!acc_new) begin
				if (offset_q == hang_out_q) begin
					stop_end = frame_q;
				end
				if (offset_q == '0) begin
					b_valid  = 1'b1;
					active_d = 1'b0;
					onset_d  = hang_in_q;
					offset_d = hang_out_q;
				end else begin
					offset_d = offset_q - HANG_W'(1);
				end
			end else begin
				offset_d = hang_out_q;
			end
			start_d = start_mid;
			stop_d  = stop_end;
		end
	end

	// Chunk report and completed-event report.
	ted_report #(
		.START_ADVANCE(START_ADVANCE),
		.LENGTH_EXTEND(LENGTH_EXTEND)
	) u_rep_chunk (
		.valid_in   (a_valid),
		.completed  (1'b0),
		.span_start (start_q),
		.span_len   (frame_q - start_q),
		.min_length (min_len_q),
		.max_length (max_len_q),
		.mode_flags (mode_q),
		.ok         (a_ok),
		.res        (a_res)
	);

	ted_report #(
		.START_ADVANCE(START_ADVANCE),
		.LENGTH_EXTEND(LENGTH_EXTEND)
	) u_rep_end (
		.valid_in   (b_valid),
		.completed  (1'b1),
		.span_start (start_mid),
		.span_len   (stop_end - start_mid),
		.min_length (min_len_q),
		.max_length (max_len_q),
		.mode_flags (mode_q),
		.ok         (b_ok),
		.res        (b_res)
	);

	// The eager notice carries the raw start frame.
	always_comb begin
		eager_res.start  = start_d;
		eager_res.length = '0;
		eager_res.status = 1'b0;
	end

	// Gather the results of this word.
	always_comb begin
		if (!active_q) begin
			push             = fe_go && eager_go;
			push_pair.two    = 1'b0;
			push_pair.first  = eager_res;
			push_pair.second = eager_res;
		end else begin
			push             = fe_go && (a_ok || b_ok);
			push_pair.two    = a_ok && b_ok;
			push_pair.first  = a_ok ? a_res : b_res;
			push_pair.second = b_res;
		end
	end

	// Configuration registers take effect after the word in the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			onset_thr_q  <= '0;
			offset_thr_q <= '0;
			hang_in_q    <= '0;
			hang_out_q   <= '0;
			min_len_q    <= '0;
			max_len_q    <= '1;
			mode_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ONSET_THR:  onset_thr_q  <= cfg_data[THR_W-1:0];
				REG_OFFSET_THR: offset_thr_q <= cfg_data[THR_W-1:0];
				REG_HANG_IN:    hang_in_q    <= cfg_data[HANG_W-1:0];
				REG_HANG_OUT:   hang_out_q   <= cfg_data[HANG_W-1:0];
				REG_MIN_LEN:    min_len_q    <= cfg_data[LEN_W-1:0];
				REG_MAX_LEN:    max_len_q    <= cfg_data[LEN_W-1:0];
				REG_MODE:       mode_q       <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Detector state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			acc_q    <= 1'b0;
			onset_q  <= '0;
			offset_q <= '0;
			chunk_q  <= '0;
			start_q  <= '0;
			stop_q   <= '0;
			frame_q  <= '0;
		end else begin
			acc_q <= acc_d;
			if (fe_go) begin
				active_q <= active_d;
				onset_q  <= onset_d;
				offset_q <= offset_d;
				chunk_q  <= chunk_d;
				start_q  <= start_d;
				stop_q   <= stop_d;
				frame_q  <= frame_q + TIME_W'(1);
			end
		end
	end

endmodule

// ===== sv/ted_out_fifo.sv =====
module ted_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  ted_pkg::res_pair_t            push_pair,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ted_pkg::TIME_W-1:0]    event_start,
	output logic [ted_pkg::OLEN_W-1:0]    event_length,
	output logic                          event_status,
	output logic                          last_result
);
	import ted_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	res_pair_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             sub_q;
	logic             pop_word;
	logic             pop_group;
	res_pair_t        head;
	res_t             cur;

	// Room for the word in the input register and one more.
	assign in_ready  = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;

	assign head = mem_q[rd_q];
	assign cur  = sub_q ? head.second : head.first;

	assign event_start  = cur.start;
	assign event_length = cur.length;
	assign event_status = cur.status;
	assign last_result  = sub_q || !head.two;

	assign pop_word  = out_valid && out_ready;
	assign pop_group = pop_word && (sub_q || !head.two);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_pair;
		end
	end

	// Pointers, fill count and position inside the head group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
			sub_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop_word) begin
				sub_q <= !pop_group;
			end
			if (pop_group) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop_group) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && pop_group) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/ted_checker.sv =====
module ted_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ted_pkg::TIME_W-1:0]      event_start,
	input logic [ted_pkg::OLEN_W-1:0]      event_length,
	input logic                            event_status,
	input logic                            last_result
);

	// With nothing queued the block always takes input.
	a_ready_when_empty: assert property (@(posedge clk)
		!out_valid |-> in_ready)
		else $error("in_ready low with an empty output queue");

	// A completed event never reports zero length.
	a_completed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_status |-> event_length != '0)
		else $error("completed event with zero length");

	// A stalled word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the word was taken");

	// A stalled word keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(event_start) && $stable(event_length) &&
			$stable(event_status) && $stable(last_result))
		else $error("output payload changed while stalled");

endmodule

bind threshold_event_detector_unit ted_checker u_ted_checker (.*);
